FILE: hdl/sample_set_statistics_unit_defines.svh
// Assertion helpers for the statistics unit.
`ifndef SAMPLE_SET_STATISTICS_UNIT_DEFINES_SVH
`define SAMPLE_SET_STATISTICS_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sss: implication check failed");

// Invariant checked on every clock edge outside reset.
`define SSS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sss: invariant check failed");

`endif

FILE: hdl/sss_pkg.sv
`default_nettype none
package sss_pkg;

	localparam int COUNT_W    = 16;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 32;
	localparam int SUMSQ_W    = 46;
	localparam int SQ_W       = 31;
	localparam int ASUM_W     = 31;
	localparam int WIDE_W     = 62;
	localparam int DIVISOR_W  = 32;
	localparam int SPLIT_W    = 23;
	localparam int PROD_W     = COUNT_W + SPLIT_W;
	localparam int ROOT_W     = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] MAX_COUNT = 16'd65535;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       has_sample;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] mean_value;
		logic [15:0]        std_dev;
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic [15:0]        sample_count;
		logic               overflowed;
	} out_item_t;

	// Snapshot of one closed set, handed from the front to the back.
	typedef struct packed {
		logic [COUNT_W-1:0]         count;
		logic signed [SUM_W-1:0]    sum;
		logic [SUMSQ_W-1:0]         sumsq;
		logic signed [SAMPLE_W-1:0] min;
		logic signed [SAMPLE_W-1:0] max;
		logic                       ovf;
	} stats_t;

	typedef struct packed {
		logic                 start;
		logic [WIDE_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WIDE_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/sss_front.sv
`default_nettype none
module sss_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sss_pkg::in_item_t in_item,
	output logic                   push,
	output sss_pkg::stats_t        push_data,
	input  wire logic              queue_full
);

	logic                                valid_s1;
	logic signed [sss_pkg::SAMPLE_W-1:0] sample_s1;
	logic [sss_pkg::SQ_W-1:0]            sq_s1;
	logic                                has_s1;
	logic                                last_s1;

	logic [sss_pkg::SAMPLE_W-1:0] mag_w;
	logic                         adv_w;
	logic                         take_w;
	sss_pkg::stats_t              acc_q;
	sss_pkg::stats_t              nx_w;

	assign mag_w = in_item.sample[sss_pkg::SAMPLE_W-1] ? (-in_item.sample) : in_item.sample;

	// A closing item may only leave stage 1 when the queue has room.
	assign adv_w    = valid_s1 && (!last_s1 || !queue_full);
	assign in_ready = !valid_s1 || adv_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_item.sample;
			sq_s1     <= sss_pkg::SQ_W'(mag_w) * sss_pkg::SQ_W'(mag_w);
			has_s1    <= in_item.has_sample;
			last_s1   <= in_item.last;
		end
	end

	always_comb begin
		take_w = has_s1 && (acc_q.count < sss_pkg::MAX_COUNT);
		nx_w   = acc_q;
		nx_w.ovf = acc_q.ovf | (has_s1 && !take_w);
		if (take_w) begin
			nx_w.count = acc_q.count + sss_pkg::COUNT_W'(1);
			nx_w.sum   = acc_q.sum + sss_pkg::SUM_W'(sample_s1);
			nx_w.sumsq = acc_q.sumsq + sss_pkg::SUMSQ_W'(sq_s1);
			if (acc_q.count == '0) begin
				nx_w.min = sample_s1;
				nx_w.max = sample_s1;
			end else begin
				if (sample_s1 < acc_q.min) nx_w.min = sample_s1;
				if (sample_s1 > acc_q.max) nx_w.max = sample_s1;
			end
		end
	end

	assign push      = adv_w && last_s1;
	assign push_data = nx_w;

	// Clear the running state once the set has been handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv_w) begin
			acc_q <= last_s1 ? '0 : nx_w;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sss_queue.sv
`default_nettype none
module sss_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sss_pkg::stats_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output sss_pkg::stats_t      head,
	output logic                 empty
);

	localparam int PTR_W = (sss_pkg::QUEUE_DEPTH > 1) ? $clog2(sss_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(sss_pkg::QUEUE_DEPTH + 1);

	sss_pkg::stats_t  entry_q [sss_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CNT_W'(sss_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sss_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sss_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sss_divider.sv
`default_nettype none
module sss_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sss_pkg::div_req_t req,
	output sss_pkg::div_rsp_t      rsp
);

	localparam int STEPS = sss_pkg::WIDE_W;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int DV_W  = sss_pkg::DIVISOR_W;

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DV_W-1:0]           rem_q;
	logic [DV_W-1:0]           div_q;
	logic [sss_pkg::WIDE_W-1:0] quo_q;

	logic [DV_W:0] rem_sh;
	logic [DV_W:0] rem_nx;
	logic          ge;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		rem_sh = {rem_q, quo_q[sss_pkg::WIDE_W-1]};
		ge     = (rem_sh >= {1'b0, div_q});
		rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			div_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx[DV_W-1:0];
			quo_q <= {quo_q[sss_pkg::WIDE_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/sss_back.sv
`default_nettype none
`include "sample_set_statistics_unit_defines.svh"
module sss_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sss_pkg::stats_t head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sss_pkg::out_item_t   out_item
);

	localparam int REM_W  = sss_pkg::ROOT_W + 2;
	localparam int SCNT_W = $clog2(sss_pkg::ROOT_W + 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL0 = 9'b000000010,
		ST_MUL1 = 9'b000000100,
		ST_ADD  = 9'b000001000,
		ST_SUB  = 9'b000010000,
		ST_DIVM = 9'b000100000,
		ST_DIVV = 9'b001000000,
		ST_SQRT = 9'b010000000,
		ST_DONE = 9'b100000000
	} back_state_t;

	back_state_t                    state_q;
	sss_pkg::stats_t                stat_q;
	logic [sss_pkg::ASUM_W-1:0]     asum_q;
	logic                           neg_q;
	logic [sss_pkg::PROD_W-1:0]     prod_lo_q;
	logic [sss_pkg::PROD_W-1:0]     prod_hi_q;
	logic [sss_pkg::WIDE_W-1:0]     sq_q;
	logic [sss_pkg::DIVISOR_W-1:0]  nn_q;
	logic [sss_pkg::WIDE_W-1:0]     nsq_q;
	logic [sss_pkg::WIDE_W-1:0]     diff_q;
	logic signed [15:0]             mean_q;
	logic [sss_pkg::WIDE_W-1:0]     x_q;
	logic [REM_W-1:0]               rem_q;
	logic [sss_pkg::ROOT_W-1:0]     root_q;
	logic [SCNT_W-1:0]              scnt_q;
	logic                           out_valid_q;
	sss_pkg::out_item_t             out_item_q;

	sss_pkg::div_req_t              div_req;
	sss_pkg::div_rsp_t              div_rsp;

	logic [sss_pkg::SUM_W-1:0]      head_abs;
	logic [REM_W+1:0]               rem_sh;
	logic [REM_W+1:0]               trial;
	logic [REM_W+1:0]               rem_nx;
	logic                           ge;
	logic [15:0]                    quo_lo;
	logic signed [16:0]             spread_w;

	sss_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign head_abs = head.sum[sss_pkg::SUM_W-1] ? (-head.sum) : head.sum;
	assign quo_lo   = div_rsp.quotient[15:0];

	// Mean division starts with the subtract; variance division follows it.
	always_comb begin
		div_req = '0;
		if (state_q == ST_SUB) begin
			div_req.start    = 1'b1;
			div_req.dividend = sss_pkg::WIDE_W'(asum_q);
			div_req.divisor  = sss_pkg::DIVISOR_W'(stat_q.count);
		end else if (state_q == ST_DIVM) begin
			div_req.start    = div_rsp.done;
			div_req.dividend = diff_q;
			div_req.divisor  = nn_q;
		end
	end

	// Square root, two radicand bits per cycle.
	always_comb begin
		rem_sh = {rem_q, x_q[sss_pkg::WIDE_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= (head.count == '0) ? ST_DONE : ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_DIVM;
				ST_DIVM: begin
					if (div_rsp.done) state_q <= ST_DIVV;
				end
				ST_DIVV: begin
					if (div_rsp.done) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (scnt_q == SCNT_W'(1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					stat_q <= head;
					asum_q <= head_abs[sss_pkg::ASUM_W-1:0];
					neg_q  <= head.sum[sss_pkg::SUM_W-1];
					mean_q <= '0;
					root_q <= '0;
				end
			end
			ST_MUL0: begin
				prod_lo_q <= sss_pkg::PROD_W'(stat_q.count)
				             * sss_pkg::PROD_W'(stat_q.sumsq[sss_pkg::SPLIT_W-1:0]);
				sq_q      <= sss_pkg::WIDE_W'(asum_q) * sss_pkg::WIDE_W'(asum_q);
				nn_q      <= sss_pkg::DIVISOR_W'(stat_q.count)
				             * sss_pkg::DIVISOR_W'(stat_q.count);
			end
			ST_MUL1: begin
				prod_hi_q <= sss_pkg::PROD_W'(stat_q.count)
				             * sss_pkg::PROD_W'(stat_q.sumsq[sss_pkg::SUMSQ_W-1:sss_pkg::SPLIT_W]);
			end
			ST_ADD: begin
				nsq_q <= sss_pkg::WIDE_W'({prod_hi_q, sss_pkg::SPLIT_W'(0)})
				         + sss_pkg::WIDE_W'(prod_lo_q);
			end
			ST_SUB: begin
				diff_q <= nsq_q - sq_q;
			end
			ST_DIVM: begin
				if (div_rsp.done) begin
					mean_q <= neg_q ? (-quo_lo) : quo_lo;
				end
			end
			ST_DIVV: begin
				if (div_rsp.done) begin
					x_q    <= div_rsp.quotient;
					rem_q  <= '0;
					root_q <= '0;
					scnt_q <= SCNT_W'(sss_pkg::ROOT_W);
				end
			end
			ST_SQRT: begin
				rem_q  <= rem_nx[REM_W-1:0];
				root_q <= {root_q[sss_pkg::ROOT_W-2:0], ge};
				x_q    <= {x_q[sss_pkg::WIDE_W-3:0], 2'b00};
				scnt_q <= scnt_q - SCNT_W'(1);
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_item_q.mean_value   <= mean_q;
					out_item_q.std_dev      <= root_q[15:0];
					out_item_q.min_value    <= stat_q.min;
					out_item_q.max_value    <= stat_q.max;
					out_item_q.sample_count <= stat_q.count;
					out_item_q.overflowed   <= stat_q.ovf;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign spread_w = 17'(out_item_q.max_value) - 17'(out_item_q.min_value);

	`SSS_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)
	`SSS_ASSERT_IMP(a_mean_in_range, clk, arst_n, out_valid_q,
		(out_item_q.mean_value >= out_item_q.min_value) &&
		(out_item_q.mean_value <= out_item_q.max_value))
	`SSS_ASSERT_IMP(a_std_bounded, clk, arst_n, out_valid_q,
		(17'(out_item_q.std_dev) << 1) <= $unsigned(spread_w))
	`SSS_ASSERT_IMP(a_empty_set_zero, clk, arst_n,
		out_valid_q && (out_item_q.sample_count == '0),
		(out_item_q.mean_value == '0) && (out_item_q.std_dev == '0))

endmodule
`default_nettype wire

FILE: hdl/sample_set_statistics_unit.sv
// Throughput: one sample item per cycle unless a close finds the queue full;
// the back end works on one set at a time, with two 62-step one-bit divisions
// and a 31-step square root per nonempty set; an empty set skips all three.
// Two closed sets may wait between front and back before input stalls on a close.
// Reset: arst_n asynchronously clears accumulators, queue, sequencer and output.
`default_nettype none
module sample_set_statistics_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sss_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sss_pkg::out_item_t     out_item
);

	logic            push;
	sss_pkg::stats_t push_data;
	logic            queue_full;
	logic            pop;
	sss_pkg::stats_t head;
	logic            queue_empty;

	sss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	sss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.head      (head),
		.empty     (queue_empty)
	);

	sss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (queue_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

FILE: tb/sv/sample_set_statistics_unit_test.sv
module sample_set_statistics_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 250;
	localparam int RANDOM_ITEMS   = 400;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	sss_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	sss_pkg::out_item_t out_item;

	sample_set_statistics_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Open-set accumulators of the predictor
	logic [sss_pkg::COUNT_W-1:0]         acc_count;
	logic signed [sss_pkg::SUM_W-1:0]    acc_sum;
	logic [sss_pkg::SUMSQ_W-1:0]         acc_sumsq;
	logic signed [sss_pkg::SAMPLE_W-1:0] acc_min;
	logic signed [sss_pkg::SAMPLE_W-1:0] acc_max;
	logic                                acc_ovf;

	sss_pkg::in_item_t  pending_samples[$];
	sss_pkg::out_item_t pending_results[$];
	int                 mismatch_count;
	int                 burst_left;
	int                 gap_left;
	int                 stall_mode;
	int                 stall_phase;
	int                 idle_cycles;
	sss_pkg::out_item_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [31:0] int_sqrt(bit [63:0] x);
		bit [31:0] root;
		bit [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic void clear_set();
		acc_count = '0;
		acc_sum   = '0;
		acc_sumsq = '0;
		acc_min   = '0;
		acc_max   = '0;
		acc_ovf   = 1'b0;
	endfunction

	// Fold one accepted item into the open set; a closing item queues its statistics.
	function automatic void fold_sample(sss_pkg::in_item_t it);
		longint             s;
		longint             n;
		longint             total;
		bit [63:0]          abs_sum;
		bit [63:0]          spread;
		sss_pkg::out_item_t r;
		s = it.sample;
		if (it.has_sample) begin
			if (acc_count == sss_pkg::MAX_COUNT) begin
				acc_ovf = 1'b1;
			end else begin
				if (acc_count == 0) begin
					acc_min = it.sample;
					acc_max = it.sample;
				end else begin
					if (it.sample < acc_min)
						acc_min = it.sample;
					if (it.sample > acc_max)
						acc_max = it.sample;
				end
				acc_count = acc_count + sss_pkg::COUNT_W'(1);
				acc_sum   = acc_sum + sss_pkg::SUM_W'(s);
				acc_sumsq = acc_sumsq + sss_pkg::SUMSQ_W'(s * s);
			end
		end
		if (!it.last)
			return;
		r = '0;
		if (acc_count != 0) begin
			n       = acc_count;
			total   = acc_sum;
			abs_sum = (total < 0) ? -total : total;
			spread  = 64'(n) * 64'(acc_sumsq) - abs_sum * abs_sum;
			r.mean_value   = 16'(total / n);
			r.std_dev      = 16'(int_sqrt(spread / (64'(n) * 64'(n))));
			r.min_value    = acc_min;
			r.max_value    = acc_max;
			r.sample_count = acc_count;
		end
		r.overflowed = acc_ovf;
		pending_results.push_back(r);
		clear_set();
	endfunction

	function automatic sss_pkg::in_item_t make_item(logic [15:0] s, logic has, logic closes);
		sss_pkg::in_item_t it;
		it.sample     = s;
		it.has_sample = has;
		it.last       = closes;
		return it;
	endfunction

	function automatic logic [15:0] pick_sample(int style, int base);
		case (style)
			0: begin
				return 16'($urandom);
			end
			1: begin
				return 16'($urandom_range(0, 512) - 256);
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
			default: begin
				return 16'(base + $urandom_range(0, 64) - 32);
			end
		endcase
	endfunction

	task automatic add_random_sets(int n_items);
		int  pushed;
		int  len;
		int  style;
		int  base;
		bit  close_on_sample;
		pushed = 0;
		while (pushed < n_items) begin
			case ($urandom_range(0, 19))
				0:       len = 0;
				1, 2:    len = $urandom_range(30, 200);
				default: len = $urandom_range(1, 12);
			endcase
			if (len > n_items - pushed)
				len = n_items - pushed;
			style           = $urandom_range(0, 3);
			base            = $urandom_range(0, 65535) - 32768;
			close_on_sample = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					pending_samples.push_back(make_item(16'($urandom), 1'b0, 1'b0));
					pushed++;
				end
				pending_samples.push_back(make_item(pick_sample(style, base), 1'b1,
					close_on_sample && (i == len - 1)));
			end
			if (!close_on_sample)
				pending_samples.push_back(make_item(16'($urandom), 1'b0, 1'b1));
			pushed += len + (close_on_sample ? 0 : 1);
		end
	endtask

	task automatic wait_drained();
		wait (pending_samples.size() == 0);
		@(negedge clk);
		while (in_valid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps, some gaps zero
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				fold_sample(in_item);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_samples.size() != 0) begin
					in_item  <= pending_samples.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch stall behavior whenever the stall phase counter wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			stall_mode  <= 0;
			stall_phase <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected result item: mean %0d std %0d min %0d",
							out_item.mean_value, out_item.std_dev, out_item.min_value);
						$display("  max %0d cnt %0d ovf %0d",
							out_item.max_value, out_item.sample_count, out_item.overflowed);
					end
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_item.mean_value !== want.mean_value
						|| out_item.std_dev !== want.std_dev
						|| out_item.min_value !== want.min_value
						|| out_item.max_value !== want.max_value
						|| out_item.sample_count !== want.sample_count
						|| out_item.overflowed !== want.overflowed) begin
						if (mismatch_count < 10) begin
							$display("mismatch: expected mean %0d std %0d min %0d max %0d cnt %0d ovf %0d",
								want.mean_value, want.std_dev, want.min_value,
								want.max_value, want.sample_count, want.overflowed);
							$display("  got mean %0d std %0d min %0d max %0d cnt %0d ovf %0d",
								out_item.mean_value, out_item.std_dev, out_item.min_value,
								out_item.max_value, out_item.sample_count, out_item.overflowed);
						end
						mismatch_count++;
					end
				end
			end
			if (stall_phase == 63) begin
				stall_phase <= 0;
				stall_mode  <= $urandom_range(0, 3);
			end else begin
				stall_phase <= stall_phase + 1;
			end
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= (stall_phase % 6 == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		mismatch_count = 0;
		clear_set();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty set, then single extreme samples
		pending_samples.push_back(make_item(16'h5a5a, 1'b0, 1'b1));
		pending_samples.push_back(make_item(16'h8000, 1'b1, 1'b1));
		pending_samples.push_back(make_item(16'h7fff, 1'b1, 1'b1));
		// both extremes, an ignored item, closed without a sample
		pending_samples.push_back(make_item(16'h7fff, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'h8000, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'h1234, 1'b0, 1'b0));
		pending_samples.push_back(make_item(16'h0000, 1'b0, 1'b1));
		// negative mean truncates toward zero
		pending_samples.push_back(make_item(-16'sd3, 1'b1, 1'b0));
		pending_samples.push_back(make_item(-16'sd4, 1'b1, 1'b1));
		pending_samples.push_back(make_item(16'd1, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'd2, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'd3, 1'b1, 1'b1));
		pending_samples.push_back(make_item(16'haaaa, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'h5555, 1'b1, 1'b1));
		// empty set right after a full one
		pending_samples.push_back(make_item(16'hffff, 1'b0, 1'b1));
		pending_samples.push_back(make_item(16'hffff, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'hffff, 1'b1, 1'b0));
		pending_samples.push_back(make_item(16'hffff, 1'b1, 1'b1));

		add_random_sets(RANDOM_ITEMS / 2);
		// hold the sender until every result is out
		wait_drained();
		add_random_sets(RANDOM_ITEMS / 2);

		// back-to-back single-sample sets
		pending_samples.push_back(make_item(16'h0100, 1'b1, 1'b1));
		pending_samples.push_back(make_item(16'h0005, 1'b1, 1'b1));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += pending_results.size();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sample_set_statistics_unit.f
+incdir+hdl
hdl/sss_pkg.sv
hdl/sss_front.sv
hdl/sss_queue.sv
hdl/sss_divider.sv
hdl/sss_back.sv
hdl/sample_set_statistics_unit.sv
tb/sv/sample_set_statistics_unit_test.sv
